// ----- hdl/plc_pkg.sv -----
// ----------------------------------------------------------------------------
// PSI limiter coefficients package
// Sizes, limits, register addresses and sequencer states of the block.
// ----------------------------------------------------------------------------
package plc_pkg;

	localparam int MAX_NODES  = 8;
	localparam int IDX_W      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W      = $clog2(MAX_NODES + 1);

	localparam int RATIO_W    = 24;
	localparam int SUM_W      = 30;
	localparam int COEF_W     = 17;
	localparam int FLOOR_W    = 16;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 3;

	localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
	localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [COEF_W-1:0]  COEF_ONE  = 17'h10000;
	localparam logic [FLOOR_W-1:0] FLOOR_RST = 16'd1;

	// Divider step counts: item ratio gives 24 quotient bits, coefficient 17.
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] ITEM_STEPS = 5'd24;
	localparam logic [STEP_W-1:0] COEF_STEPS = 5'd17;

	// Register index, taken from the word-address bit of paddr.
	localparam logic REG_RATIO_FLOOR = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_STORE,
		ST_CLOAD,
		ST_CDIV,
		ST_EMIT
	} state_t;

endpackage

// ----- hdl/psi_limiter_coefficients_top.sv -----
// ----------------------------------------------------------------------------
// PSI limiter coefficients
// Per-node residual ratios, stored and summed, then one coefficient per node.
// ----------------------------------------------------------------------------
// Busy: an accepted transaction that skips the divider (zero total, zero residual,
// sign mismatch, saturation) runs load and store, else load, 24 division steps, store.
// A last transaction then runs, per stored node, a load, up to 17 divider steps and an
// emit; each strobe follows its emit in the next cycle; the receiver cannot stall it.
// Transactions: none is taken while busy; the divider is shared by both divisions.
// Reset: asynchronous; clears the element state and sets ratio_floor to 1, store undefined.
module psi_limiter_coefficients_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// command side
	input  logic                          start,
	output logic                          busy,
	input  logic signed [31:0]            residual,
	input  logic signed [31:0]            total,
	input  logic                          last,
	// result side
	output logic                          strobe,
	output logic [plc_pkg::COEF_W-1:0]    coefficient,
	output logic                          last_coefficient,
	output logic                          zero_total,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [plc_pkg::ADDR_W-1:0]    paddr,
	input  logic [plc_pkg::DATA_W-1:0]    pwdata,
	output logic [plc_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import plc_pkg::*;

	state_t state_q, state_d;

	// Configuration
	logic [FLOOR_W-1:0] ratio_floor_q;

	// Captured transaction
	logic signed [31:0] res_q, tot_q;
	logic               last_q;

	// Element state
	logic [RATIO_W-1:0] ratio_store [MAX_NODES];
	logic [SUM_W-1:0]   ratio_sum_q;
	logic [CNT_W-1:0]   node_count_q;
	logic               zero_seen_q;
	logic [IDX_W-1:0]   k_q;

	// Shared divider
	logic [31:0]        rem_q;
	logic [31:0]        div_q;
	logic [RATIO_W-1:0] dlo_q;
	logic [RATIO_W-1:0] quo_q;
	logic [STEP_W-1:0]  cnt_q;

	// Result registers
	logic               strobe_q;
	logic [COEF_W-1:0]  coef_q;
	logic               last_coef_q;
	logic               zero_q;

	// Sequencer controls
	logic accept, do_load, do_step, do_store, do_cload, do_emit, step_done;

	// ------------------------------------------------------------------
	// Configuration port: always ready, one register at word 0.
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_RATIO_FLOOR) begin
			prdata = DATA_W'(ratio_floor_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_floor_q <= FLOOR_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_RATIO_FLOOR) begin
			ratio_floor_q <= pwdata[FLOOR_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Datapath helpers
	// ------------------------------------------------------------------
	logic [31:0]        res_mag, tot_mag;
	logic               ratio_sat;
	logic [32:0]        shifted;
	logic [33:0]        diff;
	logic               ge;
	logic [RATIO_W-1:0] floor_ext, ratio_final, ratio_rd;
	logic [SUM_W:0]     sum_add;
	logic [SUM_W-1:0]   sum_next;
	logic               store_full;
	logic               coef_big;
	logic               is_final;

	// Magnitudes of the captured operands; -2^31 maps to 2^31.
	assign res_mag   = res_q[31] ? (~res_q + 32'sd1) : res_q;
	assign tot_mag   = tot_q[31] ? (~tot_q + 32'sd1) : tot_q;
	// Quotient would exceed 24 bits exactly when |res| >= |tot| * 256.
	assign ratio_sat = {8'd0, res_mag} >= {tot_mag, 8'd0};

	// One restoring step: shift in the next dividend bit, trial subtract.
	assign shifted = {rem_q, dlo_q[RATIO_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, div_q};
	assign ge      = ~diff[33];

	assign floor_ext   = RATIO_W'(ratio_floor_q);
	assign ratio_final = (quo_q < floor_ext) ? floor_ext : quo_q;

	assign store_full = (node_count_q == CNT_W'(MAX_NODES));
	assign sum_add    = {1'b0, ratio_sum_q} + (SUM_W + 1)'(ratio_final);
	assign sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

	assign ratio_rd = ratio_store[k_q];
	// Coefficient saturates once the ratio reaches twice the sum.
	assign coef_big = {7'd0, ratio_rd} >= {ratio_sum_q, 1'b0};
	assign is_final = (CNT_W'(k_q) + CNT_W'(1)) == node_count_q;

	assign step_done = (cnt_q == STEP_W'(1));
	assign accept    = start && !busy;

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				// Special cases skip the divider.
				if (tot_q == 32'sd0 || (res_q[31] != tot_q[31]) || res_q == 32'sd0 || ratio_sat) begin
					state_d = ST_STORE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_done) state_d = ST_STORE;
			end
			ST_STORE: begin
				state_d = last_q ? ST_CLOAD : ST_IDLE;
			end
			ST_CLOAD: begin
				if (ratio_sum_q == '0 || coef_big) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_CDIV;
				end
			end
			ST_CDIV: begin
				if (step_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				state_d = is_final ? ST_IDLE : ST_CLOAD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: controls
	// ------------------------------------------------------------------
	always_comb begin
		busy     = 1'b1;
		do_load  = 1'b0;
		do_step  = 1'b0;
		do_store = 1'b0;
		do_cload = 1'b0;
		do_emit  = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy     = 1'b0;
			ST_LOAD:  do_load  = 1'b1;
			ST_DIV:   do_step  = 1'b1;
			ST_STORE: do_store = 1'b1;
			ST_CLOAD: do_cload = 1'b1;
			ST_CDIV:  do_step  = 1'b1;
			ST_EMIT:  do_emit  = 1'b1;
			default:  busy     = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Control registers: element state and result strobe
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_sum_q  <= '0;
			node_count_q <= '0;
			zero_seen_q  <= 1'b0;
			k_q          <= '0;
			cnt_q        <= '0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= do_emit;
			if (do_load) begin
				// A zero total marks the element even when the store is full.
				if (tot_q == 32'sd0) zero_seen_q <= 1'b1;
				cnt_q <= ITEM_STEPS;
			end
			if (do_step) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
			if (do_store) begin
				k_q <= '0;
				if (!store_full) begin
					node_count_q <= node_count_q + CNT_W'(1);
					ratio_sum_q  <= sum_next;
				end
			end
			if (do_cload) begin
				cnt_q <= COEF_STEPS;
			end
			if (do_emit) begin
				if (is_final) begin
					// Clear the element for the next one.
					ratio_sum_q  <= '0;
					node_count_q <= '0;
					zero_seen_q  <= 1'b0;
				end else begin
					k_q <= k_q + IDX_W'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers: captured operands, divider, store, results
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q  <= residual;
			tot_q  <= total;
			last_q <= last;
		end
		if (do_load) begin
			// Seed quotient with the special-case ratio; the divider overwrites it.
			if (tot_q == 32'sd0) begin
				quo_q <= RATIO_MAX;
			end else if ((res_q[31] != tot_q[31]) || res_q == 32'sd0) begin
				quo_q <= floor_ext;
			end else if (ratio_sat) begin
				quo_q <= RATIO_MAX;
			end
			rem_q <= res_mag >> 8;
			div_q <= tot_mag;
			dlo_q <= {res_mag[7:0], 16'd0};
		end
		if (do_step) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[RATIO_W-2:0], ge};
			dlo_q <= {dlo_q[RATIO_W-2:0], 1'b0};
		end
		if (do_store && !store_full) begin
			ratio_store[node_count_q[IDX_W-1:0]] <= ratio_final;
		end
		if (do_cload) begin
			if (ratio_sum_q == '0) begin
				quo_q <= '0;
			end else if (coef_big) begin
				quo_q <= RATIO_W'(COEF_ONE);
			end
			rem_q <= 32'(ratio_rd >> 1);
			div_q <= 32'(ratio_sum_q);
			dlo_q <= {ratio_rd[0], 23'd0};
		end
		if (do_emit) begin
			coef_q      <= (quo_q[COEF_W-1:0] > COEF_ONE) ? COEF_ONE : quo_q[COEF_W-1:0];
			last_coef_q <= is_final;
			zero_q      <= zero_seen_q;
		end
	end

	assign strobe           = strobe_q;
	assign coefficient      = coef_q;
	assign last_coefficient = last_coef_q;
	assign zero_total       = zero_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// An accepted transaction always holds the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");

	// The final coefficient of an element leaves the block idle again.
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_coefficient |-> !busy && node_count_q == '0)
		else $error("element state not cleared after final coefficient");

	// The store never counts beyond its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		node_count_q <= CNT_W'(MAX_NODES))
		else $error("node count beyond store depth");

	// A coefficient never exceeds one.
	a_coef_bound: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> coefficient <= COEF_ONE)
		else $error("coefficient above one");

endmodule

// ----- bench/plc_coef_monitor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PSI limiter coefficient monitor
// Watches the command, result and register ports of the block. Mirrors the
// per-element ratio store and sum, queues the coefficients due on each last
// node and compares every strobed result, field by field, in order.
// ----------------------------------------------------------------------------
module plc_coef_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic signed [31:0]            residual,
	input  logic signed [31:0]            total,
	input  logic                          last,
	input  logic                          strobe,
	input  logic [plc_pkg::COEF_W-1:0]    coefficient,
	input  logic                          last_coefficient,
	input  logic                          zero_total,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [plc_pkg::ADDR_W-1:0]    paddr,
	input  logic [plc_pkg::DATA_W-1:0]    pwdata,
	input  logic [plc_pkg::DATA_W-1:0]    prdata,
	input  logic                          pready,
	output int                            pending_count,
	output int                            fail_count
);
	import plc_pkg::*;

	typedef struct packed {
		logic [COEF_W-1:0] coef;
		logic              final_node;
		logic              zero_flag;
	} coef_expect_t;

	coef_expect_t       expected_coefs[$];
	coef_expect_t       head;
	logic [FLOOR_W-1:0] floor_copy;
	logic [RATIO_W-1:0] ratios[MAX_NODES];
	logic [SUM_W-1:0]   ratio_total;
	int                 nodes_held;
	bit                 zero_pending;
	int                 result_index;

	task automatic report_mismatch(input string what, input longint want, input longint got);
		if (fail_count < 40)
			$display("%0t: result %0d %s: expected %0d, got %0d",
				$realtime, result_index, what, want, got);
		fail_count++;
	endtask

	// Q8.16 ratio |res|/|tot|, clamped to [floor, RATIO_MAX]
	function automatic logic [RATIO_W-1:0] residual_ratio(input logic signed [31:0] res,
			input logic signed [31:0] tot, input logic [FLOOR_W-1:0] flr);
		longint            r;
		longint            t;
		longint unsigned   rm;
		longint unsigned   tm;
		longint unsigned   q;
		r = res;
		t = tot;
		if (t == 0)
			return RATIO_MAX;
		if ((r < 0) != (t < 0) || r == 0)
			return RATIO_W'(flr);
		rm = (r < 0) ? -r : r;
		tm = (t < 0) ? -t : t;
		q = (rm << 16) / tm;
		if (q > RATIO_MAX)
			q = RATIO_MAX;
		if (q < flr)
			q = flr;
		return q[RATIO_W-1:0];
	endfunction

	// Store one node; on the last node queue one coefficient per stored node
	task automatic absorb_node(input logic signed [31:0] res, input logic signed [31:0] tot,
			input logic lst);
		logic [RATIO_W-1:0] ratio;
		logic [SUM_W:0]     grown;
		longint unsigned    c;
		coef_expect_t       e;
		ratio = residual_ratio(res, tot, floor_copy);
		if (tot == 0)
			zero_pending = 1'b1;
		if (nodes_held < MAX_NODES) begin
			ratios[nodes_held] = ratio;
			nodes_held++;
			grown = ratio_total + ratio;
			ratio_total = (grown > SUM_MAX) ? SUM_MAX : grown[SUM_W-1:0];
		end
		if (lst) begin
			for (int k = 0; k < nodes_held; k++) begin
				c = 0;
				if (ratio_total != 0)
					c = (longint'(ratios[k]) << 16) / ratio_total;
				if (c > COEF_ONE)
					c = COEF_ONE;
				e.coef = c[COEF_W-1:0];
				e.final_node = (k == nodes_held - 1);
				e.zero_flag = zero_pending;
				expected_coefs.push_back(e);
			end
			ratio_total = '0;
			nodes_held = 0;
			zero_pending = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_copy = FLOOR_RST;
			ratio_total = '0;
			nodes_held = 0;
			zero_pending = 1'b0;
			expected_coefs.delete();
			fail_count = 0;
			pending_count = 0;
			result_index = 0;
		end else begin
			if (strobe) begin
				if (expected_coefs.size() == 0) begin
					report_mismatch("with nothing expected, coefficient", -1, coefficient);
				end else begin
					head = expected_coefs.pop_front();
					if (coefficient !== head.coef)
						report_mismatch("coefficient", head.coef, coefficient);
					if (last_coefficient !== head.final_node)
						report_mismatch("last_coefficient", head.final_node, last_coefficient);
					if (zero_total !== head.zero_flag)
						report_mismatch("zero_total", head.zero_flag, zero_total);
				end
				result_index++;
			end
			if (psel && penable && pready && paddr[2] == REG_RATIO_FLOOR) begin
				if (pwrite)
					floor_copy = pwdata[FLOOR_W-1:0];
				else if (prdata !== DATA_W'(floor_copy))
					report_mismatch("ratio_floor read", floor_copy, prdata);
			end
			if (start && !busy)
				absorb_node(residual, total, last);
			pending_count = expected_coefs.size();
		end
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PSI limiter coefficients testbench
// Drives nodal residuals element by element, with random gaps, through a
// directed part and several ratio_floor settings; a monitor predicts and
// checks every coefficient.
// ----------------------------------------------------------------------------
module testbench;
	import plc_pkg::*;

	// Worst run: ~340 items, each with a random gap, its division and, on a
	// last node, the coefficient emits of its element, plus settle pauses.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_CYCLES  = 200;
	localparam int PHASE_ITEMS   = 52;
	localparam int PHASES        = 5;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic signed [31:0]  residual;
	logic signed [31:0]  total;
	logic                last;
	logic                strobe;
	logic [COEF_W-1:0]   coefficient;
	logic                last_coefficient;
	logic                zero_total;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	int                  pending_count;
	int                  fail_count;
	int                  cycle_count = 0;
	// set per element: no gaps at all between its transactions
	bit                  calm;

	always #10 clk = ~clk;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	psi_limiter_coefficients_top uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.residual         (residual),
		.total            (total),
		.last             (last),
		.strobe           (strobe),
		.coefficient      (coefficient),
		.last_coefficient (last_coefficient),
		.zero_total       (zero_total),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	plc_coef_monitor monitor (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.residual         (residual),
		.total            (total),
		.last             (last),
		.strobe           (strobe),
		.coefficient      (coefficient),
		.last_coefficient (last_coefficient),
		.zero_total       (zero_total),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.pending_count    (pending_count),
		.fail_count       (fail_count)
	);

	// Mostly back to back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Idle gap: drop start while the gap passes; n = 0 keeps start high for the next transaction
	task automatic idle_for(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Present one node and hold it until the block takes it
	task automatic push_node(input logic [31:0] res, input logic [31:0] tot, input logic lst);
		idle_for(pick_gap());
		start <= 1'b1;
		residual <= res;
		total <= tot;
		last <= lst;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop start, wait out all expected coefficients and the block's own work
	task automatic settle(input int pause);
		start <= 1'b0;
		while (pending_count != 0 || busy)
			@(negedge clk);
		repeat (pause) @(negedge clk);
	endtask

	// One register transaction: setup cycle, then access until pready
	task automatic floor_access(input bit wr, input logic [FLOOR_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_RATIO_FLOOR, 2'b00};
		// upper bits are junk the register must ignore
		pwdata <= {16'($urandom), v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One element: a total shared by most nodes, nodes of mixed kind, last on the final node.
	// Now and then the element runs past MAX_NODES.
	task automatic run_element(output int n_items);
		int                len;
		int                mode;
		int                shift;
		bit                neg;
		longint unsigned   tmag;
		longint unsigned   rmag;
		longint            rv;
		logic [31:0]       tot;
		logic [31:0]       res;
		logic [31:0]       node_tot;
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_NODES + 1, MAX_NODES + 4)
			: $urandom_range(1, MAX_NODES);
		calm = ($urandom_range(0, 3) == 0);
		shift = $urandom_range(0, 30);
		tmag = ($urandom & ((64'd1 << shift) - 1)) | (64'd1 << shift);
		neg = $urandom_range(0, 1);
		rv = neg ? -longint'(tmag) : longint'(tmag);
		tot = rv[31:0];
		for (int i = 0; i < len; i++) begin
			mode = $urandom_range(0, 15);
			node_tot = tot;
			case (mode)
				0: begin
					// noise: any pattern in both fields
					res = $urandom;
					node_tot = $urandom;
				end
				1: begin
					res = $urandom;
					node_tot = '0;
				end
				2: begin
					// residual against the sign of the total
					rmag = $urandom_range(1, 32'h7FFF_FFFF);
					rv = neg ? longint'(rmag) : -longint'(rmag);
					res = rv[31:0];
				end
				3: begin
					// wide ratio, saturating often on small totals
					rmag = $urandom_range(0, 32'h7FFF_FFFF);
					rv = neg ? -longint'(rmag) : longint'(rmag);
					res = rv[31:0];
				end
				default: begin
					// ratio between zero and two
					rmag = $urandom_range(0, 32'(2 * tmag));
					if (rmag > 64'h7FFF_FFFF)
						rmag = 64'h7FFF_FFFF;
					rv = neg ? -longint'(rmag) : longint'(rmag);
					res = rv[31:0];
				end
			endcase
			push_node(res, node_tot, i == len - 1);
		end
		n_items = len;
	endtask

	initial begin
		int                 items;
		int                 n;
		logic [FLOOR_W-1:0] flr;

		arst_n = 1'b0;
		start = 1'b0;
		residual = '0;
		total = '0;
		last = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, ratio_floor at its reset value.
		// Single node with a saturating ratio: coefficient is one.
		push_node(32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
		// Most negative residual and total, then a sign mismatch on the floor
		push_node(32'h8000_0000, 32'h8000_0000, 1'b0);
		push_node(32'h0001_0000, 32'h8000_0000, 1'b1);
		// Zero residual, quotient under the floor, sign mismatch, zero total
		push_node(32'h0000_0000, 32'h0000_0005, 1'b0);
		push_node(32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
		push_node(32'hFFFF_FFF9, 32'h0000_0003, 1'b0);
		push_node(32'h1234_5678, 32'h0000_0000, 1'b1);
		// Element overflowing the store: nodes past MAX_NODES are dropped
		for (int i = 0; i < MAX_NODES + 2; i++)
			push_node(32'(i * 4096 + 1), 32'h0000_8000, i == MAX_NODES + 1);
		// Full element of zero totals: every ratio saturated, flag on all
		for (int i = 0; i < MAX_NODES; i++)
			push_node($urandom, 32'h0000_0000, i == MAX_NODES - 1);

		// Random part, one ratio_floor setting per phase, extremes included
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       flr = 16'hFFFF;
				2:       flr = 16'd1;
				3:       flr = 16'($urandom_range(1, 16'h0400));
				default: flr = 16'($urandom_range(1, 16'hFFFF));
			endcase
			settle(SETTLE_CYCLES);
			floor_access(1'b1, flr);
			floor_access(1'b0, '0);
			items = 0;
			while (items < PHASE_ITEMS) begin
				run_element(n);
				items += n;
			end
		end

		settle(DRAIN_CYCLES);
		if (fail_count == 0 && pending_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Abort a hung run
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

endmodule
